// ===== sv/fd_pkg.sv =====
package fd_pkg;

  // Field and register widths
  localparam int unsigned SampleWidth = 32;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned ScaleWidth  = 32;
  localparam int unsigned CfgIdxWidth = 2;

  // Stencil window
  localparam int unsigned WinDepth    = 5;
  localparam int unsigned PtsWidth    = $clog2(WinDepth + 1);
  localparam int unsigned WeightWidth = 8;

  // Datapath widths: weighted sums stay below 320 * 2^(SampleWidth-1) in magnitude
  localparam int unsigned ProdWidth = SampleWidth + WeightWidth;
  localparam int unsigned SumWidth  = SampleWidth + 10;
  localparam int unsigned MagWidth  = SampleWidth + 9;
  localparam int unsigned LoWidth   = ScaleWidth;
  localparam int unsigned HiWidth   = (MagWidth > LoWidth) ? MagWidth - LoWidth : 1;
  localparam int unsigned FullWidth = LoWidth + HiWidth + ScaleWidth + 1;

  // Job queue between front and back
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);

  localparam logic [ScaleWidth-1:0] ScaleReset = ScaleWidth'(5461);

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgFirstScale  = 2'd0,
    CfgSecondScale = 2'd1
  } cfg_idx_e;

  // Stencil variants, in emission order along a row
  typedef enum logic [2:0] {
    KindStart0 = 3'd0,
    KindStart1 = 3'd1,
    KindCentre = 3'd2,
    KindEnd1   = 3'd3,
    KindEnd0   = 3'd4
  } kind_e;

  typedef logic [SampleWidth-1:0] sample_t;
  typedef sample_t [WinDepth-1:0] window_t;

  // One queued job: a window snapshot and the span of stencils to run on it
  typedef struct packed {
    window_t win_re;
    window_t win_im;
    kind_e   kind_first;
    kind_e   kind_last;
    logic    short_row;
  } job_t;

  // Stencil weights times twelve, tap 0 is the oldest sample
  localparam logic signed [WeightWidth-1:0] D1Tab [WinDepth][WinDepth] = '{
    '{-8'sd25,  8'sd48, -8'sd36,  8'sd16, -8'sd3},
    '{-8'sd3,  -8'sd10,  8'sd18, -8'sd6,   8'sd1},
    '{ 8'sd1,  -8'sd8,   8'sd0,   8'sd8,  -8'sd1},
    '{-8'sd1,   8'sd6,  -8'sd18,  8'sd10,  8'sd3},
    '{ 8'sd3,  -8'sd16,  8'sd36, -8'sd48,  8'sd25}
  };

  localparam logic signed [WeightWidth-1:0] D2Tab [WinDepth][WinDepth] = '{
    '{ 8'sd35, -8'sd104,  8'sd114, -8'sd56,   8'sd11},
    '{ 8'sd11, -8'sd20,   8'sd6,    8'sd4,   -8'sd1},
    '{-8'sd1,   8'sd16,  -8'sd30,   8'sd16,  -8'sd1},
    '{-8'sd1,   8'sd4,    8'sd6,   -8'sd20,   8'sd11},
    '{ 8'sd11, -8'sd56,   8'sd114, -8'sd104,  8'sd35}
  };

endpackage

// ===== sv/fd_sample_if.sv =====
interface fd_sample_if;
  import fd_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] sample_re;
  logic signed [SampleWidth-1:0] sample_im;
  logic                          row_last;

  modport source (output valid, sample_re, sample_im, row_last, input ready);
  modport sink   (input valid, sample_re, sample_im, row_last, output ready);

endinterface

// ===== sv/fd_result_if.sv =====
interface fd_result_if;
  import fd_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SampleWidth-1:0] first_re;
  logic signed [SampleWidth-1:0] first_im;
  logic signed [SampleWidth-1:0] second_re;
  logic signed [SampleWidth-1:0] second_im;
  logic                          row_end;
  logic                          run_last;
  logic                          short_row;

  modport source (output valid, first_re, first_im, second_re, second_im, row_end, run_last,
                  short_row, input ready);
  modport sink   (input valid, first_re, first_im, second_re, second_im, row_end, run_last,
                  short_row, output ready);

endinterface

// ===== sv/fd_first_second_derivative_core.sv =====
// Fourth-order finite-difference first and second derivative of complex grid rows.
// sample_i carries one complex Q16.16 sample per transaction, row_last on the final
// sample of a row. result_o carries one result per grid point: both derivatives of
// real and imaginary parts, saturated Q16.16, with row_end, run_last and short_row.
// Nothing comes out for the first four samples of a row; the fifth releases points
// 0 to 2, every later sample one centred point, and row_last adds the two end points.
// A row shorter than five points gives a single all-zero result with all flags set.
// The scale registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// must write them only while the block is idle, which the block does not enforce;
// they reset to 5461. A sample's job passes through the job queue and the back's
// stage 1, stage 2, stage 3 and output registers before its first result is valid.
// The front takes one sample per cycle while the four-entry job queue has room; the
// back runs one stencil per cycle while result_o is not stalled, and a sample has up
// to five results; the back's single result pipeline sets the rate. When result_o
// stalls, the back pipeline holds and the queue fills; sample_i deasserts ready only
// once the queue is full. Reset clears the window, the row count, the queue and all
// valid flags.
module fd_first_second_derivative_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  fd_sample_if.sink                        sample_i,
  fd_result_if.source                      result_o,
  input  logic                             cfg_we_i,
  input  logic [fd_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [fd_pkg::ScaleWidth-1:0]    cfg_wdata_i
);
  import fd_pkg::*;

  logic [ScaleWidth-1:0] first_scale_q, first_scale_d;
  logic [ScaleWidth-1:0] second_scale_q, second_scale_d;
  logic                  push;
  logic                  pop;
  logic                  full;
  logic                  head_valid;
  job_t                  job;
  job_t                  head;

  // Scale registers
  always_comb begin
    first_scale_d  = first_scale_q;
    second_scale_d = second_scale_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgFirstScale:  first_scale_d  = cfg_wdata_i;
        CfgSecondScale: second_scale_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_scale_q  <= ScaleReset;
      second_scale_q <= ScaleReset;
    end else begin
      first_scale_q  <= first_scale_d;
      second_scale_q <= second_scale_d;
    end
  end

  fd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .full_i   (full),
    .push_o   (push),
    .job_o    (job)
  );

  fd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid),
    .full_o  (full)
  );

  fd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .head_valid_i   (head_valid),
    .pop_o          (pop),
    .first_scale_i  (first_scale_q),
    .second_scale_i (second_scale_q),
    .result_o       (result_o)
  );

endmodule

// ===== sv/fd_front.sv =====
module fd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  fd_sample_if.sink     sample_i,
  input  logic          full_i,
  output logic          push_o,
  output fd_pkg::job_t  job_o
);
  import fd_pkg::*;

  window_t               win_re_q, win_re_d;
  window_t               win_im_q, win_im_d;
  window_t               win_re_n, win_im_n;
  logic [PtsWidth-1:0]   pts_q, pts_d, pts_n;
  logic                  accept;
  logic                  has_centre;

  localparam logic [PtsWidth-1:0] PtsFull = PtsWidth'(WinDepth);
  localparam logic [PtsWidth-1:0] PtsPrimed = PtsWidth'(WinDepth - 1);

  assign sample_i.ready = !full_i;
  assign accept         = sample_i.valid && !full_i;

  // Shifted window and point count after this sample
  always_comb begin
    for (int i = 0; i < WinDepth - 1; i++) begin
      win_re_n[i] = win_re_q[i+1];
      win_im_n[i] = win_im_q[i+1];
    end
    win_re_n[WinDepth-1] = sample_i.sample_re;
    win_im_n[WinDepth-1] = sample_i.sample_im;
    pts_n = (pts_q < PtsFull) ? pts_q + PtsWidth'(1) : PtsFull;
  end

  // Classify: which stencils this transaction triggers
  assign has_centre = (pts_q >= PtsPrimed);

  always_comb begin
    job_o.win_re     = win_re_n;
    job_o.win_im     = win_im_n;
    job_o.kind_first = (pts_q == PtsPrimed) ? KindStart0 : KindCentre;
    job_o.kind_last  = sample_i.row_last ? KindEnd0 : KindCentre;
    job_o.short_row  = sample_i.row_last && (pts_n < PtsFull);
    push_o           = accept && (has_centre || sample_i.row_last);
  end

  // Row state update; a row end clears the window
  always_comb begin
    win_re_d = win_re_q;
    win_im_d = win_im_q;
    pts_d    = pts_q;
    if (accept) begin
      if (sample_i.row_last) begin
        win_re_d = '0;
        win_im_d = '0;
        pts_d    = '0;
      end else begin
        win_re_d = win_re_n;
        win_im_d = win_im_n;
        pts_d    = pts_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_re_q <= '0;
      win_im_q <= '0;
      pts_q    <= '0;
    end else begin
      win_re_q <= win_re_d;
      win_im_q <= win_im_d;
      pts_q    <= pts_d;
    end
  end

`ifndef SYNTHESIS
  a_pts_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pts_q <= PtsFull) else $error("point count beyond window depth");
`endif

endmodule

// ===== sv/fd_queue.sv =====
module fd_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  fd_pkg::job_t job_i,
  input  logic         pop_i,
  output fd_pkg::job_t head_o,
  output logic         valid_o,
  output logic         full_o
);
  import fd_pkg::*;

  job_t                     mem_q [QueueDepth];
  logic [QueuePtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueuePtrWidth:0]   count_q, count_d;

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == (QueuePtrWidth+1)'(QueueDepth));

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QueuePtrWidth'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QueuePtrWidth'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QueuePtrWidth+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QueuePtrWidth+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("job pushed into full queue");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("job popped from empty queue");
`endif

endmodule

// ===== sv/fd_back.sv =====
module fd_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fd_pkg::job_t                    head_i,
  input  logic                            head_valid_i,
  output logic                            pop_o,
  input  logic [fd_pkg::ScaleWidth-1:0]   first_scale_i,
  input  logic [fd_pkg::ScaleWidth-1:0]   second_scale_i,
  fd_result_if.source                     result_o
);
  import fd_pkg::*;

  localparam int unsigned NumSums = 4;  // first re, first im, second re, second im
  localparam logic [FullWidth-1:0] RoundBit = FullWidth'(1) << (FracBits - 1);
  localparam logic [FullWidth-1:0] PosMax = (FullWidth'(1) << (SampleWidth - 1)) - FullWidth'(1);

  typedef struct packed {
    logic run_last;
    logic row_end;
    logic short_row;
  } flags_t;

  logic   adv;
  logic   issue;
  kind_e  cur_kind;
  logic   last_of_job;
  kind_e  kind_q, kind_d;
  logic   busy_q, busy_d;

  // Stage 1: weighted taps
  logic                          s1_valid_q;
  flags_t                        s1_flags_q, s1_flags_d;
  logic signed [ProdWidth-1:0]   prod_q [NumSums][WinDepth];
  logic signed [ProdWidth-1:0]   prod_d [NumSums][WinDepth];
  // Stage 2: stencil sums
  logic                          s2_valid_q;
  flags_t                        s2_flags_q;
  logic signed [SumWidth-1:0]    sum_q [NumSums];
  logic signed [SumWidth-1:0]    sum_d [NumSums];
  // Stage 3: magnitude times scale, split in two partial products
  logic                                   s3_valid_q;
  flags_t                                 s3_flags_q;
  logic [NumSums-1:0]                     neg_q, neg_d;
  logic [LoWidth+ScaleWidth-1:0]          lo_prod_q [NumSums];
  logic [LoWidth+ScaleWidth-1:0]          lo_prod_d [NumSums];
  logic [HiWidth+ScaleWidth-1:0]          hi_prod_q [NumSums];
  logic [HiWidth+ScaleWidth-1:0]          hi_prod_d [NumSums];
  logic [MagWidth-1:0]                    mag [NumSums];
  logic [LoWidth+HiWidth-1:0]             mag_ext [NumSums];
  logic [ScaleWidth-1:0]                  scale [NumSums];
  // Stage 4: round, saturate, output register
  logic                          out_valid_q;
  flags_t                        out_flags_q;
  logic signed [SampleWidth-1:0] res_q [NumSums];
  logic signed [SampleWidth-1:0] res_d [NumSums];
  logic [FullWidth-1:0]          full [NumSums];
  logic [FullWidth-1:0]          quot [NumSums];
  logic [FullWidth-1:0]          lim [NumSums];
  logic [FullWidth-1:0]          sat [NumSums];

  // Whole pipeline moves when the output register can take a result
  assign adv = !out_valid_q || result_o.ready;

  // Issue one stencil of the head job per cycle while the pipeline advances
  always_comb begin
    cur_kind    = busy_q ? kind_q : head_i.kind_first;
    last_of_job = head_i.short_row || (cur_kind == head_i.kind_last);
    issue       = adv && head_valid_i;
    pop_o       = issue && last_of_job;
    kind_d      = kind_q;
    busy_d      = busy_q;
    if (issue) begin
      busy_d = !last_of_job;
      kind_d = kind_e'(cur_kind + 3'd1);
    end
    s1_flags_d.run_last  = last_of_job;
    s1_flags_d.row_end   = head_i.short_row || (cur_kind == KindEnd0);
    s1_flags_d.short_row = head_i.short_row;
  end

  // Tap products for the chosen stencil
  always_comb begin
    for (int i = 0; i < WinDepth; i++) begin
      prod_d[0][i] = ProdWidth'(D1Tab[cur_kind][i]) * ProdWidth'($signed(head_i.win_re[i]));
      prod_d[1][i] = ProdWidth'(D1Tab[cur_kind][i]) * ProdWidth'($signed(head_i.win_im[i]));
      prod_d[2][i] = ProdWidth'(D2Tab[cur_kind][i]) * ProdWidth'($signed(head_i.win_re[i]));
      prod_d[3][i] = ProdWidth'(D2Tab[cur_kind][i]) * ProdWidth'($signed(head_i.win_im[i]));
    end
  end

  // Five-term sums
  always_comb begin
    for (int j = 0; j < NumSums; j++) begin
      sum_d[j] = '0;
      for (int i = 0; i < WinDepth; i++) begin
        sum_d[j] = sum_d[j] + SumWidth'(prod_q[j][i]);
      end
    end
  end

  // Magnitude and scaling
  always_comb begin
    for (int j = 0; j < NumSums; j++) begin
      neg_d[j]     = sum_q[j][SumWidth-1];
      mag[j]       = neg_d[j] ? MagWidth'(-sum_q[j]) : MagWidth'(sum_q[j]);
      mag_ext[j]   = (LoWidth+HiWidth)'(mag[j]);
      scale[j]     = (j < 2) ? first_scale_i : second_scale_i;
      lo_prod_d[j] = (LoWidth+ScaleWidth)'(mag_ext[j][LoWidth-1:0]) *
                     (LoWidth+ScaleWidth)'(scale[j]);
      hi_prod_d[j] = (HiWidth+ScaleWidth)'(mag_ext[j][LoWidth+HiWidth-1:LoWidth]) *
                     (HiWidth+ScaleWidth)'(scale[j]);
    end
  end

  // Round half away from zero, saturate, restore sign
  always_comb begin
    for (int j = 0; j < NumSums; j++) begin
      full[j] = (FullWidth'(hi_prod_q[j]) << LoWidth) + FullWidth'(lo_prod_q[j]) + RoundBit;
      quot[j] = full[j] >> FracBits;
      lim[j]  = PosMax + FullWidth'(neg_q[j]);
      sat[j]  = (quot[j] > lim[j]) ? lim[j] : quot[j];
      res_d[j] = neg_q[j] ? -$signed(sat[j][SampleWidth-1:0]) : $signed(sat[j][SampleWidth-1:0]);
      if (s3_flags_q.short_row) begin
        res_d[j] = '0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      kind_q      <= KindStart0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      kind_q <= kind_d;
      if (adv) begin
        s1_valid_q  <= issue;
        s2_valid_q  <= s1_valid_q;
        s3_valid_q  <= s2_valid_q;
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_flags_q  <= s1_flags_d;
      prod_q      <= prod_d;
      s2_flags_q  <= s1_flags_q;
      sum_q       <= sum_d;
      s3_flags_q  <= s2_flags_q;
      neg_q       <= neg_d;
      lo_prod_q   <= lo_prod_d;
      hi_prod_q   <= hi_prod_d;
      out_flags_q <= s3_flags_q;
      res_q       <= res_d;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.first_re  = res_q[0];
  assign result_o.first_im  = res_q[1];
  assign result_o.second_re = res_q[2];
  assign result_o.second_im = res_q[3];
  assign result_o.row_end   = out_flags_q.row_end;
  assign result_o.run_last  = out_flags_q.run_last;
  assign result_o.short_row = out_flags_q.short_row;

`ifndef SYNTHESIS
  a_short_is_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_flags_q.short_row |->
      out_flags_q.run_last && out_flags_q.row_end && res_q[0] == '0 && res_q[3] == '0)
    else $error("short-row result not flagged or not zero");
  a_row_end_closes_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_flags_q.row_end |-> out_flags_q.run_last)
    else $error("row end on a result that is not the last of its run");
`endif

endmodule

// ===== sim/fd_derivative_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the scale register port, predicts every result
// from the accepted samples and compares the results in order.
module fd_derivative_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fd_sample_if                           sample_mon,
  fd_result_if                           result_mon,
  input  logic                           cfg_we_i,
  input  logic [fd_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [fd_pkg::ScaleWidth-1:0]  cfg_wdata_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import fd_pkg::*;

  typedef logic signed [SampleWidth-1:0] ssample_t;

  typedef struct packed {
    ssample_t first_re;
    ssample_t first_im;
    ssample_t second_re;
    ssample_t second_im;
    logic     row_end;
    logic     run_last;
    logic     short_row;
  } point_t;

  // Five-point weights times twelve; rows follow kind_e, column 0 is the oldest sample
  localparam int FirstWeights [WinDepth][WinDepth] = '{
    '{-25,  48, -36,  16,  -3},
    '{ -3, -10,  18,  -6,   1},
    '{  1,  -8,   0,   8,  -1},
    '{ -1,   6, -18,  10,   3},
    '{  3, -16,  36, -48,  25}
  };
  localparam int SecondWeights [WinDepth][WinDepth] = '{
    '{ 35, -104, 114,  -56,  11},
    '{ 11,  -20,   6,    4,  -1},
    '{ -1,   16, -30,   16,  -1},
    '{ -1,    4,   6,  -20,  11},
    '{ 11,  -56, 114, -104,  35}
  };

  logic [ScaleWidth-1:0] first_scale_q;
  logic [ScaleWidth-1:0] second_scale_q;
  ssample_t              row_re [WinDepth];
  ssample_t              row_im [WinDepth];
  logic [PtsWidth-1:0]   seen_q;
  point_t                expected_points [$];

  // Integer weighted sum over the current window
  function automatic longint tap_sum(input kind_e kind, input bit second, input bit imag);
    longint acc = 0;
    int     w;
    for (int i = 0; i < WinDepth; i++) begin
      w = second ? SecondWeights[int'(kind)][i] : FirstWeights[int'(kind)][i];
      acc += longint'(w) * longint'(imag ? row_im[i] : row_re[i]);
    end
    return acc;
  endfunction

  // |S| * scale, round half away from zero, saturate to the sample range
  function automatic ssample_t scale_round_sat(input longint s, input logic [ScaleWidth-1:0] scale);
    logic [79:0] mag;
    logic [79:0] q;
    logic [79:0] lim;
    mag = (s < 0) ? 80'(-s) : 80'(s);
    q   = (mag * {48'd0, scale} + (80'd1 << (FracBits - 1))) >> FracBits;
    lim = (s < 0) ? (80'd1 << (SampleWidth - 1)) : ((80'd1 << (SampleWidth - 1)) - 80'd1);
    if (q > lim) q = lim;
    if (s < 0) q = -q;
    return ssample_t'(q[SampleWidth-1:0]);
  endfunction

  function automatic point_t point_at(input kind_e kind);
    point_t p;
    p           = '0;
    p.first_re  = scale_round_sat(tap_sum(kind, 1'b0, 1'b0), first_scale_q);
    p.first_im  = scale_round_sat(tap_sum(kind, 1'b0, 1'b1), first_scale_q);
    p.second_re = scale_round_sat(tap_sum(kind, 1'b1, 1'b0), second_scale_q);
    p.second_im = scale_round_sat(tap_sum(kind, 1'b1, 1'b1), second_scale_q);
    return p;
  endfunction

  function automatic void clear_row();
    for (int i = 0; i < WinDepth; i++) begin
      row_re[i] = '0;
      row_im[i] = '0;
    end
    seen_q = '0;
  endfunction

  // Advance the window by one sample and queue the points it releases
  function automatic void predict_sample(input ssample_t re, input ssample_t im, input logic last);
    logic [PtsWidth-1:0] prev;
    point_t              batch [$];
    point_t              p;
    prev = seen_q;
    for (int i = 0; i < WinDepth - 1; i++) begin
      row_re[i] = row_re[i+1];
      row_im[i] = row_im[i+1];
    end
    row_re[WinDepth-1] = re;
    row_im[WinDepth-1] = im;
    if (seen_q < WinDepth) seen_q++;

    if (prev == WinDepth - 1) begin
      batch.push_back(point_at(KindStart0));
      batch.push_back(point_at(KindStart1));
      batch.push_back(point_at(KindCentre));
    end else if (prev >= WinDepth) begin
      batch.push_back(point_at(KindCentre));
    end

    if (last) begin
      if (seen_q < WinDepth) begin
        // short row: one all-zero point with every flag set
        batch.delete();
        p           = '0;
        p.row_end   = 1'b1;
        p.short_row = 1'b1;
        batch.push_back(p);
      end else begin
        batch.push_back(point_at(KindEnd1));
        p         = point_at(KindEnd0);
        p.row_end = 1'b1;
        batch.push_back(p);
      end
      clear_row();
    end

    if (batch.size() > 0) batch[batch.size()-1].run_last = 1'b1;
    foreach (batch[i]) expected_points.push_back(batch[i]);
  endfunction

  function automatic void check_field(input string name, input logic [SampleWidth-1:0] exp_v,
                                      input logic [SampleWidth-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  function automatic void check_point();
    point_t e;
    if (expected_points.size() == 0) begin
      $error("result transaction with no point expected");
      fail_count_o++;
    end else begin
      e = expected_points.pop_front();
      check_field("first_re",  e.first_re,  result_mon.first_re);
      check_field("first_im",  e.first_im,  result_mon.first_im);
      check_field("second_re", e.second_re, result_mon.second_re);
      check_field("second_im", e.second_im, result_mon.second_im);
      check_field("row_end",   SampleWidth'(e.row_end),   SampleWidth'(result_mon.row_end));
      check_field("run_last",  SampleWidth'(e.run_last),  SampleWidth'(result_mon.run_last));
      check_field("short_row", SampleWidth'(e.short_row), SampleWidth'(result_mon.short_row));
    end
  endfunction

  // Config, then sample, then result; a sample's points cannot leave in its own cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_scale_q  = ScaleReset;
      second_scale_q = ScaleReset;
      clear_row();
      expected_points.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgFirstScale) first_scale_q = cfg_wdata_i;
        else if (cfg_idx_i == CfgSecondScale) second_scale_q = cfg_wdata_i;
      end
      if (sample_mon.valid && sample_mon.ready)
        predict_sample(sample_mon.sample_re, sample_mon.sample_im, sample_mon.row_last);
      if (result_mon.valid && result_mon.ready) check_point();
      pending_o = expected_points.size();
    end
  end

endmodule

// ===== sim/fd_first_second_derivative_core_tb.sv =====
`timescale 1ns / 1ps

module fd_first_second_derivative_core_tb;
  import fd_pkg::*;

  localparam logic [SampleWidth-1:0] MaxSample = 32'h7FFF_FFFF;
  localparam logic [SampleWidth-1:0] MinSample = 32'h8000_0000;
  localparam logic [SampleWidth-1:0] OneSample = 32'h0001_0000;
  localparam logic [CfgIdxWidth-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CfgSpareHi = 2'd3;
  localparam int DrainCycles = 12;
  localparam int LongHold    = 120;
  localparam int PhaseItems  = 52;

  logic clk_i;
  logic rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_idx_i;
  logic [ScaleWidth-1:0]  cfg_wdata_i;
  int   fail_count;
  int   pending;
  bit   hold_req;

  fd_sample_if sample_ch ();
  fd_result_if result_ch ();

  fd_first_second_derivative_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_ch),
    .result_o    (result_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  fd_derivative_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_mon   (sample_ch),
    .result_mon   (result_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  // Mostly back to back, sometimes short gaps, rarely long ones
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic int ready_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 4);
    if (r < 85) return $urandom_range(5, 20);
    return $urandom_range(40, 80);
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [SampleWidth-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return MaxSample;
      1:       return MinSample;
      2:       return SampleWidth'($urandom_range(0, 131071)) - OneSample;
      default: return $urandom();
    endcase
  endfunction

  // Mostly full rows, some short ones, a few long ones
  function automatic int row_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return $urandom_range(1, 4);
    if (r < 90) return $urandom_range(5, 16);
    return $urandom_range(25, 40);
  endfunction

  // Called just after a rising edge; returns at the edge that took the transaction
  task automatic send_point(input logic [SampleWidth-1:0] re, input logic [SampleWidth-1:0] im,
                            input logic last);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.sample_re <= re;
    sample_ch.sample_im <= im;
    sample_ch.row_last  <= last;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
  endtask

  task automatic write_scale(input logic [CfgIdxWidth-1:0] idx, input logic [ScaleWidth-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every point has come back, then let the pipeline settle
  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [ScaleWidth-1:0] first, input logic [ScaleWidth-1:0] second);
    int len;
    int sent;
    sent = 0;
    write_scale(CfgFirstScale, first);
    write_scale(CfgSecondScale, second);
    while (sent < PhaseItems) begin
      len = row_length();
      for (int i = 0; i < len; i++) send_point(pick_sample(), pick_sample(), i == len - 1);
      sent += len;
    end
    drain();
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      repeat (ready_run()) @(posedge clk_i);
      result_ch.ready <= 1'b0;
      repeat (stall_len()) @(posedge clk_i);
    end
  end

  initial begin
    hold_req = 1'b0;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CfgFirstScale;
    cfg_wdata_i         <= '0;
    sample_ch.valid     <= 1'b0;
    sample_ch.sample_re <= '0;
    sample_ch.sample_im <= '0;
    sample_ch.row_last  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at reset scales: short rows, a minimal full row, saturation, a ramp
    send_point(MaxSample, MinSample, 1'b1);
    send_point(MinSample, MaxSample, 1'b0);
    send_point(32'd1, 32'hFFFF_FFFF, 1'b0);
    send_point(MaxSample, MaxSample, 1'b0);
    send_point(MinSample, MinSample, 1'b1);
    send_point(MaxSample, MinSample, 1'b0);
    send_point(MinSample, MaxSample, 1'b0);
    send_point(32'd0, 32'hFFFF_FFFF, 1'b0);
    send_point(32'hFFFF_FFFF, 32'd0, 1'b0);
    send_point(MaxSample, MinSample, 1'b1);
    for (int i = 0; i < 7; i++)
      send_point(i[0] ? MinSample : MaxSample, i[0] ? MaxSample : MinSample, i == 6);
    for (int i = 0; i < 6; i++)
      send_point(OneSample * i * i, -(OneSample * i), i == 5);
    drain();

    // Random rows over a spread of scale settings; spare indexes must be ignored
    write_scale(CfgSpareLo, $urandom());
    write_scale(CfgSpareHi, $urandom());
    run_phase(32'h0001_0000, 32'h0001_0000);
    hold_req = 1'b1;
    run_phase(32'h0000_0000, 32'hFFFF_FFFF);
    run_phase(32'hFFFF_FFFF, 32'h0000_0000);
    run_phase($urandom(), $urandom());
    run_phase(ScaleReset, 32'd1);
    run_phase($urandom_range(0, 65535), $urandom_range(0, 65535));

    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/fd_pkg.sv
sv/fd_sample_if.sv
sv/fd_result_if.sv
sv/fd_front.sv
sv/fd_queue.sv
sv/fd_back.sv
sv/fd_first_second_derivative_core.sv
sim/fd_derivative_checker.sv
sim/fd_first_second_derivative_core_tb.sv
